FILE: rtl/core/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
// Used by the interfaces, controller, datapath, top level and checker; no dependencies.
`default_nettype none

package rrts_pkg;

   // width of the slot index as seen on the result channel
   localparam int TASK_W = 4;
   localparam int STATUS_W = 2;
   localparam int FUNC_W = 3;
   localparam int TIME_W = 32;
   localparam int LOCK_W = 8;

   typedef enum logic [FUNC_W-1:0] {
      FN_CREATE    = 3'd0,
      FN_START     = 3'd1,
      FN_SLEEP     = 3'd2,
      FN_TICK      = 3'd3,
      FN_ENTER_CRIT = 3'd4,
      FN_EXIT_CRIT = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_STARTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECODE,
      CTL_WAKE,
      CTL_SEARCH,
      CTL_FINISH
   } ctl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_op;
      logic exec;
      logic scan_init;
      logic scan;
      logic search_init;
      logic search;
      logic rsp_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_tick;
      logic tick_go;
      logic wake_done;
      logic search_end;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/rrts_if.sv
// Valid/ready channel interfaces for the scheduler's request and response.
// Depends on rrts_pkg for field widths.
`default_nettype none

interface rrts_req_if;
   logic                             valid;
   logic                             ready;
   logic [rrts_pkg::FUNC_W-1:0]      func;
   logic [rrts_pkg::TIME_W-1:0]      now;
   logic [rrts_pkg::TIME_W-1:0]      delay;

   modport source (output valid, output func, output now, output delay, input ready);
   modport sink (input valid, input func, input now, input delay, output ready);
endinterface

interface rrts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rrts_pkg::TASK_W-1:0]      current_task;
   logic [rrts_pkg::STATUS_W-1:0]    status;
   logic                             switch_request;
   logic                             scheduler_ran;

   modport source (output valid, output current_task, output status,
                   output switch_request, output scheduler_ran, input ready);
   modport sink (input valid, input current_task, input status,
                 input switch_request, input scheduler_ran, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rrts_ctrl.sv
// Controller state machine of the scheduler: sequences decode, wakeup scan,
// round-robin search and response. Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rrts_pkg::stat_type stat,
   output rrts_pkg::cmd_type      cmd
);

   rrts_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rrts_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_op = 1'b1;
               state_in    = rrts_pkg::CTL_DECODE;
            end
         end
         rrts_pkg::CTL_DECODE: begin
            cmd.exec = 1'b1;
            if (stat.is_tick && stat.tick_go) begin
               cmd.scan_init = 1'b1;
               state_in      = rrts_pkg::CTL_WAKE;
            end else begin
               state_in = rrts_pkg::CTL_FINISH;
            end
         end
         rrts_pkg::CTL_WAKE: begin
            if (stat.wake_done) begin
               cmd.search_init = 1'b1;
               state_in        = rrts_pkg::CTL_SEARCH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         rrts_pkg::CTL_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_end) begin
               state_in = rrts_pkg::CTL_FINISH;
            end
         end
         rrts_pkg::CTL_FINISH: begin
            // hold here while the previous result still waits downstream
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = rrts_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/rrts_dp.sv
// Datapath of the scheduler: slot table, wakeup time memory, scan and search
// counters, and the response register. Driven by rrts_ctrl; depends on rrts_pkg.
`default_nettype none

module rrts_dp #(
   parameter int MAX_TASKS = 12,
   localparam int IDX_W = $clog2(MAX_TASKS),
   localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rrts_pkg::cmd_type               cmd,
   output rrts_pkg::stat_type                   stat,
   input  wire logic [rrts_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [rrts_pkg::TIME_W-1:0]     req_now,
   input  wire logic [rrts_pkg::TIME_W-1:0]     req_delay,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [rrts_pkg::TASK_W-1:0]          rsp_current_task,
   output logic [rrts_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_switch_request,
   output logic                                 rsp_scheduler_ran
);

   // latched request
   logic [rrts_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [rrts_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [rrts_pkg::TIME_W-1:0]   delay_ff, delay_in;

   // scheduler state
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              apps_ff, apps_in;
   logic [IDX_W-1:0]              running_ff, running_in;
   logic [rrts_pkg::LOCK_W-1:0]   lock_ff, lock_in;
   logic                          started_ff, started_in;
   // a slot is ready or running unless its sleep bit is set
   logic [MAX_TASKS-1:0]          sleep_ff, sleep_in;

   // per-transaction result bits
   logic [rrts_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          sw_ff, sw_in;
   logic                          ran_ff, ran_in;

   // wakeup scan pipeline
   logic [CNT_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [rrts_pkg::TIME_W-1:0]   rd_data_ff;

   // round-robin search
   logic [IDX_W-1:0]              cand_ff, cand_in;
   logic [CNT_W-1:0]              step_ff, step_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::TASK_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [rrts_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_sw_ff, rsp_sw_in;
   logic                          rsp_ran_ff, rsp_ran_in;

   // wakeup time memory; only slots below count_ff are ever read and each of
   // them was written by create or start first, so no clearing is needed
   logic [rrts_pkg::TIME_W-1:0]   wake_mem [MAX_TASKS];
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [rrts_pkg::TIME_W-1:0]   wr_data;
   logic                          rd_en;

   logic [IDX_W-1:0]              new_slot;
   logic                          apps_full;
   logic                          tick_go;
   logic                          issue;
   logic [rrts_pkg::TIME_W-1:0]   wake_diff;
   logic [CNT_W-1:0]              cand_inc;
   logic [IDX_W-1:0]              nx;
   logic                          hit;
   logic                          last;

   always_comb begin
      new_slot  = IDX_W'(apps_ff + CNT_W'(1));
      apps_full = (apps_ff == CNT_W'(MAX_TASKS - 1));
      tick_go   = started_ff && (count_ff > CNT_W'(1)) && (lock_ff == '0);
      issue     = (rd_idx_ff != count_ff);
      wake_diff = now_ff - rd_data_ff;
      cand_inc  = CNT_W'(cand_ff) + CNT_W'(1);
      nx        = (cand_inc == count_ff) ? '0 : cand_inc[IDX_W-1:0];
      hit       = !sleep_ff[nx];
      // true while testing the final candidate of the round
      last      = ((CNT_W+1)'(step_ff) + (CNT_W+1)'(2)) == (CNT_W+1)'(count_ff);

      stat.is_tick    = (func_ff == rrts_pkg::FN_TICK);
      stat.tick_go    = tick_go;
      stat.wake_done  = !issue && !chk_vld_ff;
      stat.search_end = hit || last;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      func_in    = func_ff;
      now_in     = now_ff;
      delay_in   = delay_ff;
      count_in   = count_ff;
      apps_in    = apps_ff;
      running_in = running_ff;
      lock_in    = lock_ff;
      started_in = started_ff;
      sleep_in   = sleep_ff;
      status_in  = status_ff;
      sw_in      = sw_ff;
      ran_in     = ran_ff;
      rd_idx_in  = rd_idx_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      cand_in    = cand_ff;
      step_in    = step_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;

      if (cmd.load_op) begin
         func_in  = req_func;
         now_in   = req_now;
         delay_in = req_delay;
      end

      if (cmd.exec) begin
         status_in = rrts_pkg::STAT_OK;
         sw_in     = 1'b0;
         ran_in    = 1'b0;
         unique case (func_ff)
            rrts_pkg::FN_CREATE: begin
               priority if (started_ff) begin
                  status_in = rrts_pkg::STAT_STARTED;
               end else if (apps_full) begin
                  status_in = rrts_pkg::STAT_FULL;
               end else begin
                  apps_in            = apps_ff + CNT_W'(1);
                  count_in           = count_ff + CNT_W'(1);
                  sleep_in[new_slot] = 1'b0;
                  wr_en              = 1'b1;
                  wr_addr            = new_slot;
               end
            end
            rrts_pkg::FN_START: begin
               if (!started_ff) begin
                  sleep_in[0] = 1'b0;
                  wr_en       = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  running_in  = '0;
                  started_in  = 1'b1;
               end
            end
            rrts_pkg::FN_SLEEP: begin
               if (started_ff) begin
                  wr_en                = 1'b1;
                  wr_addr              = running_ff;
                  wr_data              = now_ff + delay_ff;
                  sleep_in[running_ff] = 1'b1;
                  sw_in                = 1'b1;
               end
            end
            rrts_pkg::FN_TICK: begin
               ran_in = tick_go;
            end
            rrts_pkg::FN_ENTER_CRIT: begin
               lock_in = lock_ff + rrts_pkg::LOCK_W'(1);
            end
            rrts_pkg::FN_EXIT_CRIT: begin
               lock_in = lock_ff - rrts_pkg::LOCK_W'(1);
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_init) begin
         rd_idx_in  = '0;
         chk_vld_in = 1'b0;
      end

      // one read issued and one slot tested per cycle
      if (cmd.scan) begin
         rd_en      = issue;
         chk_vld_in = issue;
         chk_idx_in = rd_idx_ff[IDX_W-1:0];
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         if (chk_vld_ff && sleep_ff[chk_idx_ff] && !wake_diff[rrts_pkg::TIME_W-1]) begin
            sleep_in[chk_idx_ff] = 1'b0;
         end
      end

      if (cmd.search_init) begin
         cand_in = running_ff;
         step_in = '0;
      end

      if (cmd.search) begin
         priority if (hit) begin
            running_in = nx;
         end else if (last) begin
            // nothing ready: idle runs whatever its state
            running_in  = '0;
            sleep_in[0] = 1'b0;
         end else begin
            cand_in = nx;
            step_in = step_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_ran_in    = rsp_ran_ff;
      if (cmd.rsp_load) begin
         rsp_task_in   = rrts_pkg::TASK_W'(running_ff);
         rsp_status_in = status_ff;
         rsp_sw_in     = sw_ff;
         rsp_ran_in    = ran_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         apps_ff      <= '0;
         running_ff   <= '0;
         lock_ff      <= '0;
         started_ff   <= 1'b0;
         sleep_ff     <= '0;
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         apps_ff      <= apps_in;
         running_ff   <= running_in;
         lock_ff      <= lock_in;
         started_ff   <= started_in;
         sleep_ff     <= sleep_in;
         rd_idx_ff    <= rd_idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      now_ff        <= now_in;
      delay_ff      <= delay_in;
      status_ff     <= status_in;
      sw_ff         <= sw_in;
      ran_ff        <= ran_in;
      chk_idx_ff    <= chk_idx_in;
      cand_ff       <= cand_in;
      step_ff       <= step_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_ran_ff    <= rsp_ran_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wake_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= wake_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_task   = rsp_task_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_switch_request = rsp_sw_ff;
   assign rsp_scheduler_ran  = rsp_ran_ff;

endmodule

`default_nettype wire

FILE: rtl/core/round_robin_task_scheduler.sv
// Round-robin task scheduler with sleep: top level joining controller and datapath.
// Depends on rrts_pkg, rrts_if, rrts_ctrl and rrts_dp.
//
// Usage:
//   req_bus carries one operation per transaction (func, now, delay); rsp_bus
//   returns exactly one result per operation (current_task, status,
//   switch_request, scheduler_ran), in order.
//   One operation is in work at a time. Create, start, sleep, critical-section
//   and skipped ticks pass through accept, decode and result on their way to
//   the result register. A tick that runs adds the wakeup scan and the search,
//   with N tasks in use (idle included): the wakeup scan reads one slot per
//   cycle from the wakeup time memory, then the round-robin search tests one
//   candidate slot per cycle, 1 to N - 1 of them.
//   The next operation can be accepted in the cycle after a result is loaded, even
//   while that result still waits on rsp_bus; if rsp_bus stalls, the following
//   result waits in the block until the register frees up.
//   Reset (synchronous) empties the task table, clears the lock counter and
//   the started flag and drops any pending result; no clearing pass is needed.
`default_nettype none

module round_robin_task_scheduler #(
   parameter int MAX_TASKS = 12
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rrts_req_if.sink    req_bus,
   rrts_rsp_if.source  rsp_bus
);

   rrts_pkg::cmd_type  cmd;
   rrts_pkg::stat_type stat;
   logic               req_ready;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_bus.func),
      .req_now            (req_bus.now),
      .req_delay          (req_bus.delay),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_current_task   (rsp_bus.current_task),
      .rsp_status         (rsp_bus.status),
      .rsp_switch_request (rsp_bus.switch_request),
      .rsp_scheduler_ran  (rsp_bus.scheduler_ran)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

FILE: rtl/core/rrts_checker.sv
// Port-level checks for the round-robin task scheduler, bound to its top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
`default_nettype none

module rrts_checker #(
   parameter int MAX_TASKS = 12
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [rrts_pkg::TASK_W-1:0]       rsp_current_task,
   input wire logic [rrts_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic                              rsp_switch_request,
   input wire logic                              rsp_scheduler_ran
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_task)
         && $stable(rsp_status) && $stable(rsp_switch_request)
         && $stable(rsp_scheduler_ran))
      else $error("stalled result changed");

   // only one operation in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // at most one kind of effect per result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_switch_request && rsp_scheduler_ran)
         && (rsp_status == rrts_pkg::STAT_OK
             || (!rsp_switch_request && !rsp_scheduler_ran)))
      else $error("conflicting result flags");

   // running slot stays inside the table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_TASKS > 15) || (int'(rsp_current_task) < MAX_TASKS))
      else $error("current task out of range");

   // reset drops any pending result
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind round_robin_task_scheduler rrts_checker #(
   .MAX_TASKS (MAX_TASKS)
) u_rrts_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_current_task   (rsp_bus.current_task),
   .rsp_status         (rsp_bus.status),
   .rsp_switch_request (rsp_bus.switch_request),
   .rsp_scheduler_ran  (rsp_bus.scheduler_ran)
);

`default_nettype wire

FILE: tb/sv/rrts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the round-robin task scheduler: mirrors the task table, predicts
// one result per accepted request and compares responses in order. Depends on rrts_pkg.
module rrts_scoreboard #(
   parameter int MAX_SLOTS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [rrts_pkg::FUNC_W-1:0]     req_func,
   input  logic [rrts_pkg::TIME_W-1:0]     req_now,
   input  logic [rrts_pkg::TIME_W-1:0]     req_delay,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [rrts_pkg::TASK_W-1:0]     rsp_current_task,
   input  logic [rrts_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            rsp_switch_request,
   input  logic                            rsp_scheduler_ran,
   output int                              fail_count,
   output int                              pending,
   output int                              checked,
   output int                              ticks_ran,
   output int                              sleeps
);

   typedef enum logic [1:0] {
      SLOT_READY    = 2'd0,
      SLOT_RUNNING  = 2'd1,
      SLOT_SLEEPING = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic [rrts_pkg::TASK_W-1:0]   cur_slot;
      logic [rrts_pkg::STATUS_W-1:0] status;
      logic                          switch_req;
      logic                          ran;
   } sched_result_type;

   slot_state_type              slot_st[MAX_SLOTS];
   logic [rrts_pkg::TIME_W-1:0] wake_at[MAX_SLOTS];
   int unsigned                 slots_used;
   int unsigned                 cur_slot;
   int unsigned                 apps;
   logic [rrts_pkg::LOCK_W-1:0] lock_depth;
   logic                        started;
   sched_result_type            expected_q[$];

   function automatic void clear_table();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_st[i] = SLOT_READY;
         wake_at[i] = '0;
      end
      slots_used = 0;
      cur_slot   = 0;
      apps       = 0;
      lock_depth = '0;
      started    = 1'b0;
   endfunction

   function automatic void run_tick(input logic [rrts_pkg::TIME_W-1:0] now);
      logic [rrts_pkg::TIME_W-1:0] late;
      int unsigned                 nx;
      logic                        found;
      found = 1'b0;
      // a sleeper wakes once now has reached its wakeup time, modulo 2^32
      for (int i = 0; i < slots_used && i < MAX_SLOTS; i++) begin
         late = now - wake_at[i];
         if (slot_st[i] == SLOT_SLEEPING && !late[rrts_pkg::TIME_W-1]) begin
            slot_st[i] = SLOT_READY;
         end
      end
      if (slot_st[cur_slot] == SLOT_RUNNING) begin
         slot_st[cur_slot] = SLOT_READY;
      end
      for (int i = 1; i < slots_used && !found; i++) begin
         nx = (cur_slot + i) % slots_used;
         if (nx < MAX_SLOTS && slot_st[nx] == SLOT_READY) begin
            cur_slot    = nx;
            slot_st[nx] = SLOT_RUNNING;
            found       = 1'b1;
         end
      end
      // nothing ready: idle runs whatever its state
      if (!found) begin
         cur_slot   = 0;
         slot_st[0] = SLOT_RUNNING;
      end
   endfunction

   function automatic sched_result_type schedule_op(
      input logic [rrts_pkg::FUNC_W-1:0] func,
      input logic [rrts_pkg::TIME_W-1:0] now,
      input logic [rrts_pkg::TIME_W-1:0] delay);
      sched_result_type res;
      res = '0;
      res.status = rrts_pkg::STAT_OK;
      case (func)
         rrts_pkg::FN_CREATE: begin
            if (started) begin
               res.status = rrts_pkg::STAT_STARTED;
            end else if (apps >= MAX_SLOTS - 1) begin
               res.status = rrts_pkg::STAT_FULL;
            end else begin
               slot_st[apps + 1] = SLOT_READY;
               wake_at[apps + 1] = '0;
               apps++;
               slots_used++;
            end
         end
         rrts_pkg::FN_START: begin
            if (!started) begin
               slot_st[0] = SLOT_RUNNING;
               wake_at[0] = '0;
               slots_used++;
               cur_slot   = 0;
               started    = 1'b1;
            end
         end
         rrts_pkg::FN_SLEEP: begin
            if (started) begin
               wake_at[cur_slot] = now + delay;
               slot_st[cur_slot] = SLOT_SLEEPING;
               res.switch_req    = 1'b1;
            end
         end
         rrts_pkg::FN_TICK: begin
            if (started && slots_used > 1 && lock_depth == '0) begin
               run_tick(now);
               res.ran = 1'b1;
            end
         end
         rrts_pkg::FN_ENTER_CRIT: lock_depth = lock_depth + 1'b1;
         rrts_pkg::FN_EXIT_CRIT:  lock_depth = lock_depth - 1'b1;
         default: ;
      endcase
      res.cur_slot = cur_slot[rrts_pkg::TASK_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      sched_result_type want;
      int               errs;
      if (reset) begin
         clear_table();
         expected_q.delete();
         fail_count <= 0;
         pending    <= 0;
         checked    <= 0;
         ticks_ran  <= 0;
         sleeps     <= 0;
      end else begin
         errs = 0;
         // retire first: a response never belongs to the request taken in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected response: current_task %0d", rsp_current_task);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_current_task !== want.cur_slot) begin
                  $error("current_task: expected %0d, actual %0d",
                         want.cur_slot, rsp_current_task);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_switch_request !== want.switch_req) begin
                  $error("switch_request: expected %0b, actual %0b",
                         want.switch_req, rsp_switch_request);
                  errs++;
               end
               if (rsp_scheduler_ran !== want.ran) begin
                  $error("scheduler_ran: expected %0b, actual %0b",
                         want.ran, rsp_scheduler_ran);
                  errs++;
               end
            end
            checked <= checked + 1;
         end
         if (req_valid && req_ready) begin
            want = schedule_op(req_func, req_now, req_delay);
            expected_q.push_back(want);
            if (want.ran) begin
               ticks_ran <= ticks_ran + 1;
            end
            if (want.switch_req) begin
               sleeps <= sleeps + 1;
            end
         end
         fail_count <= fail_count + errs;
         pending    <= expected_q.size();
      end
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, request and response traffic, verdict.
// Depends on rrts_pkg, rrts_if, round_robin_task_scheduler and rrts_scoreboard.
module tb;

   localparam int N_TASKS      = 12;
   localparam int RANDOM_OPS   = 1250;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   // func codes the block treats as no-ops
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   int fail_count;
   int pending;
   int checked;
   int ticks_ran;
   int sleeps;
   int stall_cycles = 0;

   logic steady   = 1'b0;
   logic hold_req = 1'b0;

   round_robin_task_scheduler #(
      .MAX_TASKS(N_TASKS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   rrts_scoreboard #(
      .MAX_SLOTS(N_TASKS)
   ) u_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_func          (req_bus.func),
      .req_now           (req_bus.now),
      .req_delay         (req_bus.delay),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_current_task  (rsp_bus.current_task),
      .rsp_status        (rsp_bus.status),
      .rsp_switch_request(rsp_bus.switch_request),
      .rsp_scheduler_ran (rsp_bus.scheduler_ran),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked),
      .ticks_ran         (ticks_ran),
      .sleeps            (sleeps)
   );

   // response side: random back-pressure plus one long hold-off
   initial begin : rsp_drive
      logic hold_done;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 20);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_op(input logic [rrts_pkg::FUNC_W-1:0] func,
                          input logic [rrts_pkg::TIME_W-1:0] now,
                          input logic [rrts_pkg::TIME_W-1:0] delay);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.now   <= now;
      req_bus.delay <= delay;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [rrts_pkg::LOCK_W-1:0] lock_est;
      logic [rrts_pkg::TIME_W-1:0] now_ctr;
      logic [rrts_pkg::TIME_W-1:0] now_val;
      logic [rrts_pkg::TIME_W-1:0] delay_val;
      logic [rrts_pkg::FUNC_W-1:0] func;
      int                          pick;
      int                          sent;
      req_bus.valid = 1'b0;
      req_bus.func  = rrts_pkg::FN_CREATE;
      req_bus.now   = '0;
      req_bus.delay = '0;
      lock_est = '0;
      now_ctr  = 32'hFFFF_FF80;
      sent     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // before start: spare code, ignored tick and sleep, then fill the table past full
      send_op(FN_SPARE_6, $urandom(), $urandom());
      send_op(rrts_pkg::FN_TICK, $urandom(), $urandom());
      send_op(rrts_pkg::FN_SLEEP, $urandom(), $urandom());
      repeat (N_TASKS) send_op(rrts_pkg::FN_CREATE, $urandom(), $urandom());
      send_op(rrts_pkg::FN_START, '0, '0);
      send_op(rrts_pkg::FN_START, '1, '1);
      send_op(rrts_pkg::FN_CREATE, '0, '0);
      // idle sleeps until 0xfffffffe, lock wraps down and back, tick at zero wakes it
      send_op(rrts_pkg::FN_SLEEP, '1, '1);
      send_op(rrts_pkg::FN_EXIT_CRIT, '0, '0);
      send_op(rrts_pkg::FN_TICK, '1, '0);
      send_op(rrts_pkg::FN_ENTER_CRIT, '0, '0);
      send_op(rrts_pkg::FN_TICK, '0, '0);
      send_op(rrts_pkg::FN_SLEEP, '0, '0);
      send_op(FN_SPARE_7, $urandom(), $urandom());

      while (sent < RANDOM_OPS) begin
         steady = (sent >= 300 && sent < 500);
         if (sent == 700) begin
            hold_req = 1'b1;
         end
         pick      = $urandom_range(0, 99);
         now_val   = ($urandom_range(0, 99) < 8) ? $urandom() : now_ctr;
         delay_val = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 24);
         if (lock_est != 0 && $urandom_range(0, 3) == 0) begin
            // steer the lock back to zero, upward if it wrapped
            func = lock_est[rrts_pkg::LOCK_W-1] ? rrts_pkg::FN_ENTER_CRIT
                                                : rrts_pkg::FN_EXIT_CRIT;
         end else if (pick < 50) begin
            func = rrts_pkg::FN_TICK;
            now_ctr = now_ctr + $urandom_range(0, 4);
         end else if (pick < 85) begin
            func = rrts_pkg::FN_SLEEP;
         end else if (pick < 90) begin
            func = ($urandom_range(0, 3) == 0) ? rrts_pkg::FN_EXIT_CRIT
                                                : rrts_pkg::FN_ENTER_CRIT;
         end else if (pick < 95) begin
            func = rrts_pkg::FN_CREATE;
         end else if (pick < 97) begin
            func = rrts_pkg::FN_START;
         end else begin
            func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
         end
         if (func == rrts_pkg::FN_ENTER_CRIT) begin
            lock_est = lock_est + 1'b1;
         end else if (func == rrts_pkg::FN_EXIT_CRIT) begin
            lock_est = lock_est - 1'b1;
         end
         sent++;
         send_op(func, now_val, delay_val);
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions on a %0d-slot table: %0d ticks ran, %0d sleeps,",
               checked, N_TASKS, ticks_ran, sleeps);
      $display("with lock wrap, full table, late creates and wrapping wakeup times");
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
